FILE: hdl/assert_macros.svh
// assertion macros for the rtl files
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/crfp_pkg.sv
// shared types, character codes and text-field parse functions for the
// chamber reply frame parser; no dependencies
package crfp_pkg;

   localparam int DEF_FRAME_CAPACITY = 64;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int TEMP_W  = 15;
   localparam int HUMID_W = 7;
   localparam int WORD_W  = 16;
   localparam int WHOLE_W = 17;
   localparam int TENTH_W = 20;

   // every decoded frame position lies in this range, so only this range is stored
   localparam int STORE_LO      = 2;
   localparam int STORE_HI      = 47;
   localparam int POS_KIND      = 2;
   localparam int POS_TEMP_ACT  = 3;
   localparam int POS_HUM_ACT   = 9;
   localparam int POS_TEMP_SEC  = 14;
   localparam int POS_ERR       = 20;
   localparam int POS_TEMP_SET  = 23;
   localparam int POS_HUM_SET   = 29;
   localparam int POS_CHANNELS  = 32;
   localparam int FIELD_LEN     = 5;
   localparam int HUMID_LEN     = 2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_STX   = 8'h02;
   localparam logic [7:0] CH_ETX   = 8'h03;
   localparam logic [7:0] CH_ACK   = 8'h06;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NAK   = 8'h15;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_T     = 8'h54;

   localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -15'sd999;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 15'sd9999;
   localparam logic [HUMID_W-1:0]       HUMID_MAX = 7'd99;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_NAK   = 2'd2,
      KIND_DATA  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_BLANK,
      PH_WHOLE,
      PH_FRAC,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic               neg;
      logic [WHOLE_W-1:0] whole;
      logic [3:0]         frac;
   } parse_type;

   typedef logic [FIELD_LEN-1:0][BYTE_W-1:0] field_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // scan of blanks, sign, integer digits, then at most one fraction digit;
   // chars[0] is the first character of the field
   function automatic parse_type parse_field(input field_type chars);
      parse_type  r;
      phase_type  ph;
      logic [7:0] c;
      logic [3:0] d;
      r  = '0;
      ph = PH_BLANK;
      for (int k = 0; k < FIELD_LEN; k++) begin
         c = chars[k];
         d = c[3:0];
         unique case (ph)
            PH_BLANK: begin
               priority if (is_blank(c)) begin
                  ph = PH_BLANK;
               end else if (c == CH_PLUS || c == CH_MINUS) begin
                  r.neg = (c == CH_MINUS);
                  ph    = PH_WHOLE;
               end else if (is_digit(c)) begin
                  r.whole = WHOLE_W'(d);
                  ph      = PH_WHOLE;
               end else if (c == CH_DOT) begin
                  ph = PH_FRAC;
               end else begin
                  ph = PH_DONE;
               end
            end
            PH_WHOLE: begin
               priority if (is_digit(c)) begin
                  r.whole = WHOLE_W'((r.whole << 3) + (r.whole << 1) + WHOLE_W'(d));
               end else if (c == CH_DOT) begin
                  ph = PH_FRAC;
               end else begin
                  ph = PH_DONE;
               end
            end
            PH_FRAC: begin
               if (is_digit(c)) begin
                  r.frac = d;
               end
               ph = PH_DONE;
            end
            PH_DONE: begin
               ph = PH_DONE;
            end
            default: begin
               ph = PH_DONE;
            end
         endcase
      end
      return r;
   endfunction

   // signed tenths, saturated to the temperature range
   function automatic logic signed [TEMP_W-1:0] to_temp(input parse_type p);
      logic [TENTH_W-1:0] v;
      logic signed [TEMP_W-1:0] t;
      v = (TENTH_W'(p.whole) << 3) + (TENTH_W'(p.whole) << 1) + TENTH_W'(p.frac);
      if (p.neg) begin
         t = (v > TENTH_W'(999)) ? TEMP_MIN : -$signed(TEMP_W'(v));
      end else begin
         t = (v > TENTH_W'(9999)) ? TEMP_MAX : $signed(TEMP_W'(v));
      end
      return t;
   endfunction

   // whole percent; any negative value saturates to zero
   function automatic logic [HUMID_W-1:0] to_humid(input parse_type p);
      logic [HUMID_W-1:0] h;
      if (p.neg) begin
         h = '0;
      end else if (p.whole > WHOLE_W'(HUMID_MAX)) begin
         h = HUMID_MAX;
      end else begin
         h = HUMID_W'(p.whole);
      end
      return h;
   endfunction

endpackage

FILE: hdl/crfp_if.sv
// valid/ready channel interfaces for the frame parser: received bytes in,
// decoded replies out; depends on crfp_pkg
interface crfp_req_if;
   logic                         valid;
   logic                         ready;
   logic [crfp_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface crfp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [crfp_pkg::KIND_W-1:0]         reply_kind;
   logic                                last_acknowledged;
   logic signed [crfp_pkg::TEMP_W-1:0]  temp_actual;
   logic [crfp_pkg::HUMID_W-1:0]        humid_actual;
   logic signed [crfp_pkg::TEMP_W-1:0]  temp_second;
   logic [crfp_pkg::WORD_W-1:0]         error_chars;
   logic signed [crfp_pkg::TEMP_W-1:0]  temp_setpoint;
   logic [crfp_pkg::HUMID_W-1:0]        humid_setpoint;
   logic [crfp_pkg::WORD_W-1:0]         channel_bits;

   modport source (output valid, output reply_kind, output last_acknowledged,
                   output temp_actual, output humid_actual, output temp_second,
                   output error_chars, output temp_setpoint, output humid_setpoint,
                   output channel_bits, input ready);
   modport sink (input valid, input reply_kind, input last_acknowledged,
                 input temp_actual, input humid_actual, input temp_second,
                 input error_chars, input temp_setpoint, input humid_setpoint,
                 input channel_bits, output ready);
endinterface

FILE: hdl/chamber_reply_frame_parser.sv
// chamber_reply_frame_parser: accepts one word per cycle, back to back, unless an etx word waits
// the reply for a frame goes valid after its etx is accepted, by way of the decode flag and
// then the result register (store update, then decode into the result register)
// an etx word waits only while an unread result sits in the result register
// synchronous reset clears position, byte store, flags and all held values
// depends on crfp_pkg, crfp_if.sv and assert_macros.svh
`include "assert_macros.svh"

module chamber_reply_frame_parser #(
   parameter int FRAME_CAPACITY = crfp_pkg::DEF_FRAME_CAPACITY
) (
   input  logic            clock,
   input  logic            reset,
   crfp_req_if.sink        req_chan,
   crfp_rsp_if.source      rsp_chan
);

   localparam int POS_W = $clog2(FRAME_CAPACITY + 1);
   localparam logic [POS_W-1:0] POS_CAP = POS_W'(FRAME_CAPACITY);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             decode_ff, decode_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       store_ff [crfp_pkg::STORE_LO:crfp_pkg::STORE_HI];

   crfp_pkg::kind_type                         kind_ff, kind_in;
   logic                                       ack_ff, ack_in;
   logic signed [crfp_pkg::TEMP_W-1:0]         temp_act_ff, temp_act_in;
   logic signed [crfp_pkg::TEMP_W-1:0]         temp_sec_ff, temp_sec_in;
   logic signed [crfp_pkg::TEMP_W-1:0]         temp_set_ff, temp_set_in;
   logic [crfp_pkg::HUMID_W-1:0]               hum_act_ff, hum_act_in;
   logic [crfp_pkg::HUMID_W-1:0]               hum_set_ff, hum_set_in;
   logic [crfp_pkg::WORD_W-1:0]                err_ff, err_in;
   logic [crfp_pkg::WORD_W-1:0]                chan_ff, chan_in;

   logic       take, in_frame, is_etx, store_we, rsp_free;
   logic [7:0] rx;
   logic [7:0] sel;

   crfp_pkg::field_type f_temp_act, f_temp_sec, f_temp_set, f_hum_act, f_hum_set;
   logic [crfp_pkg::WORD_W-1:0] chan_bits;

   // ---------------- byte intake ----------------
   assign rx       = req_chan.rx_byte;
   assign is_etx   = (rx == crfp_pkg::CH_ETX);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   // only an ETX needs the result slot in the following cycle
   assign req_chan.ready = rsp_free || !is_etx;
   assign take     = req_chan.valid && req_chan.ready;
   // at position zero only STX opens a frame
   assign in_frame = take && ((pos_ff != '0) || (rx == crfp_pkg::CH_STX));
   assign store_we = in_frame && (pos_ff < POS_CAP);

   always_comb begin
      pos_in    = pos_ff;
      decode_in = 1'b0;
      if (in_frame) begin
         if (is_etx) begin
            pos_in    = '0;
            decode_in = 1'b1;
         end else if (pos_ff < POS_CAP) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         decode_ff <= 1'b0;
         for (int i = crfp_pkg::STORE_LO; i <= crfp_pkg::STORE_HI; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         pos_ff    <= pos_in;
         decode_ff <= decode_in;
         if (store_we) begin
            for (int i = crfp_pkg::STORE_LO; i <= crfp_pkg::STORE_HI; i++) begin
               if (pos_ff == POS_W'(i)) begin
                  store_ff[i] <= rx;
               end
            end
         end
      end
   end

   // decode, in the cycle after ETX
   // the store is quiet here: after ETX only an STX at position zero enters a frame, and it is not stored
   always_comb begin
      for (int k = 0; k < crfp_pkg::FIELD_LEN; k++) begin
         f_temp_act[k] = store_ff[crfp_pkg::POS_TEMP_ACT + k];
         f_temp_sec[k] = store_ff[crfp_pkg::POS_TEMP_SEC + k];
         f_temp_set[k] = store_ff[crfp_pkg::POS_TEMP_SET + k];
         if (k < crfp_pkg::HUMID_LEN) begin
            f_hum_act[k] = store_ff[crfp_pkg::POS_HUM_ACT + k];
            f_hum_set[k] = store_ff[crfp_pkg::POS_HUM_SET + k];
         end else begin
            f_hum_act[k] = crfp_pkg::CH_NUL;
            f_hum_set[k] = crfp_pkg::CH_NUL;
         end
      end
      for (int i = 0; i < crfp_pkg::WORD_W; i++) begin
         chan_bits[i] = (store_ff[crfp_pkg::POS_CHANNELS + i] == crfp_pkg::CH_ONE);
      end
   end

   assign sel = store_ff[crfp_pkg::POS_KIND];

   always_comb begin
      kind_in     = kind_ff;
      ack_in      = ack_ff;
      temp_act_in = temp_act_ff;
      temp_sec_in = temp_sec_ff;
      temp_set_in = temp_set_ff;
      hum_act_in  = hum_act_ff;
      hum_set_in  = hum_set_ff;
      err_in      = err_ff;
      chan_in     = chan_ff;
      if (decode_ff) begin
         priority if (sel == crfp_pkg::CH_ACK) begin
            kind_in = crfp_pkg::KIND_ACK;
            ack_in  = 1'b1;
         end else if (sel == crfp_pkg::CH_NAK) begin
            kind_in = crfp_pkg::KIND_NAK;
            ack_in  = 1'b0;
         end else if (sel == crfp_pkg::CH_T) begin
            kind_in     = crfp_pkg::KIND_DATA;
            temp_act_in = crfp_pkg::to_temp(crfp_pkg::parse_field(f_temp_act));
            temp_sec_in = crfp_pkg::to_temp(crfp_pkg::parse_field(f_temp_sec));
            temp_set_in = crfp_pkg::to_temp(crfp_pkg::parse_field(f_temp_set));
            // a leading minus marks an unavailable humidity
            if (store_ff[crfp_pkg::POS_HUM_ACT] != crfp_pkg::CH_MINUS) begin
               hum_act_in = crfp_pkg::to_humid(crfp_pkg::parse_field(f_hum_act));
            end
            if (store_ff[crfp_pkg::POS_HUM_SET] != crfp_pkg::CH_MINUS) begin
               hum_set_in = crfp_pkg::to_humid(crfp_pkg::parse_field(f_hum_set));
            end
            err_in  = {store_ff[crfp_pkg::POS_ERR], store_ff[crfp_pkg::POS_ERR + 1]};
            chan_in = chan_bits;
         end else begin
            kind_in = crfp_pkg::KIND_OTHER;
         end
      end
   end

   always_comb begin
      if (decode_ff) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   // the held values double as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         kind_ff      <= crfp_pkg::KIND_OTHER;
         ack_ff       <= 1'b0;
         temp_act_ff  <= '0;
         temp_sec_ff  <= '0;
         temp_set_ff  <= '0;
         hum_act_ff   <= '0;
         hum_set_ff   <= '0;
         err_ff       <= '0;
         chan_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         ack_ff       <= ack_in;
         temp_act_ff  <= temp_act_in;
         temp_sec_ff  <= temp_sec_in;
         temp_set_ff  <= temp_set_in;
         hum_act_ff   <= hum_act_in;
         hum_set_ff   <= hum_set_in;
         err_ff       <= err_in;
         chan_ff      <= chan_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.reply_kind        = kind_ff;
   assign rsp_chan.last_acknowledged = ack_ff;
   assign rsp_chan.temp_actual       = temp_act_ff;
   assign rsp_chan.humid_actual      = hum_act_ff;
   assign rsp_chan.temp_second       = temp_sec_ff;
   assign rsp_chan.error_chars       = err_ff;
   assign rsp_chan.temp_setpoint     = temp_set_ff;
   assign rsp_chan.humid_setpoint    = hum_set_ff;
   assign rsp_chan.channel_bits      = chan_ff;

   // ---------------- checks ----------------
   `ASSERT_ALWAYS(a_pos_saturates, pos_ff <= POS_CAP, "frame position ran past capacity")
   `ASSERT_ALWAYS(a_decode_slot_free, !decode_ff || !rsp_valid_ff, "decode with slot busy")
   `ASSERT_ALWAYS(a_decode_at_zero, !decode_ff || (pos_ff == '0), "decode while frame open")
   `ASSERT_NEXT(a_decode_loads, decode_ff, rsp_valid_ff, "decode did not load a result")
   `ASSERT_ALWAYS(a_hum_act_range, hum_act_ff <= crfp_pkg::HUMID_MAX, "humidity out of range")
   `ASSERT_ALWAYS(a_hum_set_range, hum_set_ff <= crfp_pkg::HUMID_MAX, "setpoint out of range")

endmodule
